/* rtl/tsm_pkg.sv */
`timescale 1ns / 1ps

package tsm_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int LINE_AW    = $clog2(MAX_WIDTH);
	localparam int ELEV_W     = 20;
	localparam int CS_W       = 24;
	localparam int NUM_BOUNDS = 254;

	localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

	// register indexes of the configuration port
	localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_CELL_X      = 3'd2;
	localparam logic [2:0] CFG_CELL_Y      = 3'd3;
	localparam logic [2:0] CFG_NO_DATA     = 3'd4;

	localparam logic [8:0]               GRID_RST    = 9'd256;
	localparam logic [CS_W-1:0]          CELL_RST    = 24'd256;
	localparam logic signed [ELEV_W-1:0] NO_DATA_RST = -20'sd79992;

	typedef enum logic [2:0] {
		T_IDLE,
		T_READ,
		T_LAUNCH,
		T_WAIT,
		T_PUT
	} top_state_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_EX,
		E_EY,
		E_P,
		E_NUM,
		E_DEN,
		E_CMP
	} eng_state_t;

	typedef struct packed {
		logic                     valid;
		logic signed [ELEV_W-1:0] lft;
		logic signed [ELEV_W-1:0] rgt;
		logic signed [ELEV_W-1:0] upv;
		logic signed [ELEV_W-1:0] dnv;
	} slope_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] code;
	} slope_resp_t;

	typedef logic [NUM_BOUNDS:0][31:0] trig_tab_t;

	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// squared cosine or sine of k*pi/510 in Q31, by successive rotation in Q62
	function automatic trig_tab_t build_tab(input logic want_sin);
		logic [63:0] one, a, a2, a3, a4, a5, a6, sa, ca, c, s, p, q, nc, ns, sq;
		trig_tab_t t;
		one = 64'd1 << 62;
		a = PI_Q61 / 64'd255;
		a2 = qmul(a, a);
		a3 = qmul(a2, a);
		a4 = qmul(a2, a2);
		a5 = qmul(a4, a);
		a6 = qmul(a4, a2);
		sa = a - a3 / 64'd6 + a5 / 64'd120;
		ca = one - a2 / 64'd2 + a4 / 64'd24 - a6 / 64'd720;
		c = one;
		s = 64'd0;
		sq = qmul(c, c) >> 31;
		t[0] = want_sin ? 32'd0 : sq[31:0];
		for (int k = 1; k <= NUM_BOUNDS; k++) begin
			p = qmul(c, ca);
			q = qmul(s, sa);
			nc = (p >= q) ? p - q : 64'd0;
			ns = qmul(s, ca) + qmul(c, sa);
			c = nc;
			s = ns;
			sq = want_sin ? (qmul(s, s) >> 31) : (qmul(c, c) >> 31);
			t[k] = sq[31:0];
		end
		return t;
	endfunction

	localparam trig_tab_t COS2_TAB = build_tab(1'b0);
	localparam trig_tab_t SIN2_TAB = build_tab(1'b1);

endpackage

/* rtl/terrain_slope_map_top.sv */
`timescale 1ns / 1ps

// terrain slope map: elevation samples enter in raster order on the s_ side,
// one beat per grid cell; slope codes leave on the m_ side with the column and
// row of their cell. results lag one row; an input beat makes zero to four
// result beats, the last one flagged by m_tlast. a cell with a no-data
// neighbor gives code 0.
// an input beat reads and writes the line buffer; each result it causes is
// then computed in the slope unit: three single products, eight and four
// partial products for the squared terms, and an eight-step search over the
// angle boundaries of seven partial products each, all on one shared 32x32
// multiplier. a no-data result skips this. the next input beat is taken once
// all results of the last one are queued in the output register, even while
// m_tready holds the last result back; a stalled receiver stops the block
// when the next result is ready. reset sets the configuration to 256x256
// cells, 1 m spacing and no-data code -79992 and starts at row 0, column 0.
// the line buffers need no clearing. configuration is to be written by the
// user through cfg_we/cfg_index/cfg_data while idle, which is not enforced.
module terrain_slope_map_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // elevation[19:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // col[7:0], row[15:8], slope_code[23:16]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	tsm_pkg::top_state_t st_q, st_d;

	logic [8:0]  width_q, height_q;
	logic [23:0] csx_q, csy_q;
	logic signed [19:0] nodata_q;

	logic [7:0] col_q, row_q, cur_c_q, cur_r_q;
	logic signed [19:0] e_q, m2_q, u2_q, win0_q, win1_q, win2_q, win3_q, d2_q;
	logic c_is1_q, c_ge1_q, c_ge2_q, r_is1_q;
	logic [3:0] slot_v_q, slot_rest, slot_v_new;
	logic [1:0] slot_q;
	logic       out_free, row_end, last_row, finish, launch;
	logic [8:0] w_eff, h_eff;

	logic [39:0] rd_data;
	logic        ram_we;

	logic        out_v_q, out_last_q;
	logic [23:0] out_data_q;

	tsm_pkg::slope_req_t  req;
	tsm_pkg::slope_resp_t resp;

	function automatic logic [1:0] first_slot(input logic [3:0] m);
		if (m[0]) return 2'd0;
		if (m[1]) return 2'd1;
		if (m[2]) return 2'd2;
		return 2'd3;
	endfunction

	assign w_eff = (width_q < 9'd2) ? 9'd2 :
		((width_q > 9'(tsm_pkg::MAX_WIDTH)) ? 9'(tsm_pkg::MAX_WIDTH) : width_q);
	assign h_eff = (height_q < 9'd2) ? 9'd2 :
		((height_q > 9'(tsm_pkg::MAX_HEIGHT)) ? 9'(tsm_pkg::MAX_HEIGHT) : height_q);
	assign row_end = {1'b0, col_q} >= w_eff - 9'd1;
	assign last_row = {1'b0, row_q} >= h_eff - 9'd1;

	// results of this beat: inner cell of the row above, its row end, and
	// on the last row the cells of the row itself
	assign slot_v_new[0] = (row_q != 8'd0) && (col_q != 8'd0);
	assign slot_v_new[1] = (row_q != 8'd0) && row_end;
	assign slot_v_new[2] = (row_q != 8'd0) && last_row && (col_q != 8'd0);
	assign slot_v_new[3] = (row_q != 8'd0) && last_row && row_end;

	assign slot_rest = slot_v_q & ~(4'd1 << slot_q);
	assign out_free = !out_v_q || m_tready;

	tsm_ram #(
		.WIDTH(2 * tsm_pkg::ELEV_W),
		.DEPTH(tsm_pkg::MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (ram_we),
		.waddr(col_q),
		.wdata({rd_data[19:0], e_q}),
		.raddr(col_q),
		.rdata(rd_data)
	);

	always_comb begin
		req.valid = launch;
		req.lft = win0_q;
		req.rgt = m2_q;
		req.upv = win2_q;
		req.dnv = win3_q;
		case (slot_q)
			2'd0: begin
				req.lft = c_is1_q ? win1_q : win0_q;
				req.rgt = m2_q;
				req.upv = r_is1_q ? win1_q : win2_q;
				req.dnv = win3_q;
			end
			2'd1: begin
				req.lft = c_ge1_q ? win1_q : m2_q;
				req.rgt = m2_q;
				req.upv = r_is1_q ? m2_q : u2_q;
				req.dnv = e_q;
			end
			2'd2: begin
				req.lft = c_ge2_q ? d2_q : win3_q;
				req.rgt = e_q;
				req.upv = win1_q;
				req.dnv = win3_q;
			end
			default: begin
				req.lft = c_ge1_q ? win3_q : e_q;
				req.rgt = e_q;
				req.upv = m2_q;
				req.dnv = e_q;
			end
		endcase
	end

	tsm_slope u_slope (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.csx    (csx_q),
		.csy    (csy_q),
		.no_data(nodata_q),
		.resp   (resp)
	);

	always_comb begin
		st_d = st_q;
		s_tready = 1'b0;
		ram_we = 1'b0;
		launch = 1'b0;
		finish = 1'b0;
		unique case (st_q)
			tsm_pkg::T_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) st_d = tsm_pkg::T_READ;
			end
			tsm_pkg::T_READ: begin
				ram_we = 1'b1;
				if (slot_v_new == 4'd0) begin
					finish = 1'b1;
					st_d = tsm_pkg::T_IDLE;
				end else begin
					st_d = tsm_pkg::T_LAUNCH;
				end
			end
			tsm_pkg::T_LAUNCH: begin
				launch = 1'b1;
				st_d = tsm_pkg::T_WAIT;
			end
			tsm_pkg::T_WAIT: begin
				if (resp.done) st_d = tsm_pkg::T_PUT;
			end
			tsm_pkg::T_PUT: begin
				if (out_free) begin
					if (slot_rest == 4'd0) begin
						finish = 1'b1;
						st_d = tsm_pkg::T_IDLE;
					end else begin
						st_d = tsm_pkg::T_LAUNCH;
					end
				end
			end
			default: st_d = tsm_pkg::T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tsm_pkg::T_IDLE;
			col_q <= 8'd0;
			row_q <= 8'd0;
			slot_v_q <= 4'd0;
			out_v_q <= 1'b0;
			width_q <= tsm_pkg::GRID_RST;
			height_q <= tsm_pkg::GRID_RST;
			csx_q <= tsm_pkg::CELL_RST;
			csy_q <= tsm_pkg::CELL_RST;
			nodata_q <= tsm_pkg::NO_DATA_RST;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				unique case (cfg_index)
					tsm_pkg::CFG_GRID_WIDTH:  width_q <= cfg_data[8:0];
					tsm_pkg::CFG_GRID_HEIGHT: height_q <= cfg_data[8:0];
					tsm_pkg::CFG_CELL_X:      csx_q <= cfg_data;
					tsm_pkg::CFG_CELL_Y:      csy_q <= cfg_data;
					tsm_pkg::CFG_NO_DATA:     nodata_q <= cfg_data[19:0];
					default: ;
				endcase
			end
			if (st_q == tsm_pkg::T_READ) begin
				slot_v_q <= slot_v_new;
				if (row_end) begin
					col_q <= 8'd0;
					row_q <= last_row ? 8'd0 : row_q + 8'd1;
				end else begin
					col_q <= col_q + 8'd1;
				end
			end
			if (st_q == tsm_pkg::T_PUT && out_free) begin
				out_v_q <= 1'b1;
				slot_v_q <= slot_rest;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == tsm_pkg::T_IDLE && s_tvalid) begin
			e_q <= s_tdata[19:0];
		end
		if (st_q == tsm_pkg::T_READ) begin
			m2_q <= rd_data[19:0];
			u2_q <= rd_data[39:20];
			cur_c_q <= col_q;
			cur_r_q <= row_q;
			c_is1_q <= (col_q == 8'd1);
			c_ge1_q <= (col_q != 8'd0);
			c_ge2_q <= (col_q > 8'd1);
			r_is1_q <= (row_q == 8'd1);
			slot_q <= first_slot(slot_v_new);
		end
		if (st_q == tsm_pkg::T_PUT && out_free) begin
			slot_q <= first_slot(slot_rest);
			out_data_q[7:0] <= (slot_q == 2'd0 || slot_q == 2'd2) ? cur_c_q - 8'd1 : cur_c_q;
			out_data_q[15:8] <= (slot_q == 2'd0 || slot_q == 2'd1) ? cur_r_q - 8'd1 : cur_r_q;
			out_data_q[23:16] <= resp.code;
			out_last_q <= (slot_rest == 4'd0);
		end
		if (finish) begin
			// slide the neighbor window once per input beat
			win0_q <= win1_q;
			win1_q <= (st_q == tsm_pkg::T_READ) ? rd_data[19:0] : m2_q;
			win2_q <= (st_q == tsm_pkg::T_READ) ? rd_data[39:20] : u2_q;
			win3_q <= e_q;
			d2_q <= win3_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_data_q;
	assign m_tlast = out_last_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		resp.done |-> st_q == tsm_pkg::T_WAIT)
		else $error("slope unit finished outside of a wait");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		resp.done |-> resp.code != 8'd255)
		else $error("slope search passed the last boundary");

	a_slot_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == tsm_pkg::T_LAUNCH || st_q == tsm_pkg::T_WAIT ||
		st_q == tsm_pkg::T_PUT) |-> slot_v_q != 4'd0)
		else $error("result in flight with no pending slot");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == tsm_pkg::T_PUT && out_free && slot_rest == 4'd0) |=>
		st_q == tsm_pkg::T_IDLE && out_v_q && out_last_q)
		else $error("final result of a beat not flagged");

endmodule

/* rtl/tsm_ram.sv */
`timescale 1ns / 1ps

module tsm_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/tsm_slope.sv */
`timescale 1ns / 1ps

module tsm_slope (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tsm_pkg::slope_req_t               req,
	input  logic [tsm_pkg::CS_W-1:0]          csx,
	input  logic [tsm_pkg::CS_W-1:0]          csy,
	input  logic signed [tsm_pkg::ELEV_W-1:0] no_data,
	output tsm_pkg::slope_resp_t              resp
);

	tsm_pkg::eng_state_t st_q, st_d;
	logic [3:0]   step_q;
	logic [3:0]   nsteps;
	logic [2:0]   bit_q;
	logic [7:0]   code_q;
	logic         done_q;
	logic [19:0]  ax_q, ay_q;
	logic [23:0]  csx_q, csy_q;
	logic [43:0]  ex_q, ey_q;
	logic [47:0]  p_q;
	logic [96:0]  num_q;
	logic [95:0]  den_q;
	logic [130:0] acc_q;
	logic [63:0]  prod_s1;
	logic [6:0]   sh_s1;
	logic         sub_s1, clr_s1, vld_s1;

	logic [31:0]  opa, opb;
	logic [6:0]   sh;
	logic         sub;
	logic         issue, consume, start, nodata, pass;
	logic [21:0]  xl, xh;
	logic [7:0]   cand, idx;
	logic [20:0]  dx, dy;
	logic [130:0] term, base;

	assign start = (st_q == tsm_pkg::E_IDLE) && req.valid;
	assign nodata = (req.lft == no_data) || (req.rgt == no_data) ||
		(req.upv == no_data) || (req.dnv == no_data);
	assign dx = {req.rgt[19], req.rgt} - {req.lft[19], req.lft};
	assign dy = {req.dnv[19], req.dnv} - {req.upv[19], req.upv};

	assign xl = step_q[2] ? ey_q[21:0] : ex_q[21:0];
	assign xh = step_q[2] ? ey_q[43:22] : ex_q[43:22];
	assign cand = code_q | (8'd1 << bit_q);
	assign idx = (cand == 8'd255) ? 8'd254 : cand;
	assign pass = !acc_q[130] && (cand != 8'd255);

	always_comb begin
		opa = 32'd0;
		opb = 32'd0;
		sh = 7'd0;
		sub = 1'b0;
		nsteps = 4'd1;
		unique case (st_q)
			tsm_pkg::E_EX: begin
				opa = {12'd0, ax_q};
				opb = {8'd0, csy_q};
			end
			tsm_pkg::E_EY: begin
				opa = {12'd0, ay_q};
				opb = {8'd0, csx_q};
			end
			tsm_pkg::E_P: begin
				opa = {8'd0, csx_q};
				opb = {8'd0, csy_q};
			end
			tsm_pkg::E_NUM: begin
				nsteps = 4'd8;
				case (step_q[1:0])
					2'd0: begin opa = {10'd0, xl}; opb = {10'd0, xl}; sh = 7'd0; end
					2'd1: begin opa = {10'd0, xl}; opb = {10'd0, xh}; sh = 7'd22; end
					2'd2: begin opa = {10'd0, xh}; opb = {10'd0, xl}; sh = 7'd22; end
					default: begin opa = {10'd0, xh}; opb = {10'd0, xh}; sh = 7'd44; end
				endcase
			end
			tsm_pkg::E_DEN: begin
				nsteps = 4'd4;
				case (step_q[1:0])
					2'd0: begin opa = {8'd0, p_q[23:0]}; opb = {8'd0, p_q[23:0]}; sh = 7'd0; end
					2'd1: begin opa = {8'd0, p_q[23:0]}; opb = {8'd0, p_q[47:24]}; sh = 7'd24; end
					2'd2: begin opa = {8'd0, p_q[47:24]}; opb = {8'd0, p_q[23:0]}; sh = 7'd24; end
					default: begin opa = {8'd0, p_q[47:24]}; opb = {8'd0, p_q[47:24]}; sh = 7'd48; end
				endcase
			end
			tsm_pkg::E_CMP: begin
				// num*cos2 - den*sin2, sign decides the boundary
				nsteps = 4'd7;
				opb = tsm_pkg::COS2_TAB[idx];
				case (step_q)
					4'd0: opa = num_q[31:0];
					4'd1: begin opa = num_q[63:32]; sh = 7'd32; end
					4'd2: begin opa = num_q[95:64]; sh = 7'd64; end
					4'd3: begin opa = {31'd0, num_q[96]}; sh = 7'd96; end
					4'd4: begin opa = den_q[31:0]; opb = tsm_pkg::SIN2_TAB[idx]; sub = 1'b1; end
					4'd5: begin
						opa = den_q[63:32]; opb = tsm_pkg::SIN2_TAB[idx]; sh = 7'd32; sub = 1'b1;
					end
					default: begin
						opa = den_q[95:64]; opb = tsm_pkg::SIN2_TAB[idx]; sh = 7'd64; sub = 1'b1;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign issue = (st_q != tsm_pkg::E_IDLE) && (step_q < nsteps);
	assign consume = (st_q != tsm_pkg::E_IDLE) && (step_q == nsteps + 4'd1);

	assign term = {67'd0, prod_s1} << sh_s1;
	assign base = clr_s1 ? '0 : acc_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			tsm_pkg::E_IDLE: if (start && !nodata) st_d = tsm_pkg::E_EX;
			tsm_pkg::E_EX:   if (consume) st_d = tsm_pkg::E_EY;
			tsm_pkg::E_EY:   if (consume) st_d = tsm_pkg::E_P;
			tsm_pkg::E_P:    if (consume) st_d = tsm_pkg::E_NUM;
			tsm_pkg::E_NUM:  if (consume) st_d = tsm_pkg::E_DEN;
			tsm_pkg::E_DEN:  if (consume) st_d = tsm_pkg::E_CMP;
			tsm_pkg::E_CMP:  if (consume && bit_q == 3'd0) st_d = tsm_pkg::E_IDLE;
			default: st_d = tsm_pkg::E_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tsm_pkg::E_IDLE;
			step_q <= 4'd0;
			bit_q <= 3'd7;
			done_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			st_q <= st_d;
			done_q <= 1'b0;
			vld_s1 <= issue;
			if (st_q == tsm_pkg::E_IDLE || consume) begin
				step_q <= 4'd0;
			end else begin
				step_q <= step_q + 4'd1;
			end
			if (start) begin
				bit_q <= 3'd7;
				done_q <= nodata;
			end else if (consume && st_q == tsm_pkg::E_CMP) begin
				if (bit_q == 3'd0) begin
					done_q <= 1'b1;
				end else begin
					bit_q <= bit_q - 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			prod_s1 <= {32'd0, opa} * {32'd0, opb};
			sh_s1 <= sh;
			sub_s1 <= sub;
			clr_s1 <= (step_q == 4'd0);
		end
		if (vld_s1) begin
			acc_q <= sub_s1 ? base - term : base + term;
		end
		if (start) begin
			ax_q <= dx[20] ? 20'(-dx) : dx[19:0];
			ay_q <= dy[20] ? 20'(-dy) : dy[19:0];
			csx_q <= (csx == '0) ? 24'd1 : csx;
			csy_q <= (csy == '0) ? 24'd1 : csy;
			code_q <= 8'd0;
		end
		if (consume) begin
			case (st_q)
				tsm_pkg::E_EX:  ex_q <= acc_q[43:0];
				tsm_pkg::E_EY:  ey_q <= acc_q[43:0];
				tsm_pkg::E_P:   p_q <= acc_q[47:0];
				tsm_pkg::E_NUM: num_q <= {acc_q[88:0], 8'd0};
				tsm_pkg::E_DEN: den_q <= acc_q[95:0];
				tsm_pkg::E_CMP: if (pass) code_q <= cand;
				default: ;
			endcase
		end
	end

	assign resp.done = done_q;
	assign resp.code = code_q;

endmodule
